>>> rtl/drmt_pkg.sv
package drmt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DISPLAYED_DEF = 8;
    localparam int RECENT_LIMIT_DEF  = 4;
    localparam int KEY_BITS_DEF      = 32;

    // Fixed field widths of the beats
    localparam int OP_W       = 2;
    localparam int KEY_PORT_W = 32;
    localparam int CUR_RANK_W = 4;
    localparam int REC_RANK_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_STAGE  = 2'd1,
        OP_COMMIT = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef struct packed {
        logic                  in_current;
        logic                  in_recent;
        logic [CUR_RANK_W-1:0] current_rank;
        logic [REC_RANK_W-1:0] recent_rank;
    } t_result;

endpackage

>>> rtl/drmt_key_ram.sv
module drmt_key_ram #(
    parameter int DEPTH = 24,
    parameter int W     = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/drmt_ctrl.sv
module drmt_ctrl #(
    parameter int MAX_DISPLAYED = drmt_pkg::MAX_DISPLAYED_DEF,
    parameter int RECENT_LIMIT  = drmt_pkg::RECENT_LIMIT_DEF,
    parameter int KW            = drmt_pkg::KEY_BITS_DEF,
    parameter int AW            = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [drmt_pkg::OP_W-1:0]      i_op,
    input  logic [drmt_pkg::KEY_PORT_W-1:0] i_key,
    input  logic                           i_key_valid,
    input  logic                           i_out_busy,
    output logic                           o_res_load,
    output drmt_pkg::t_result              o_res,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [KW-1:0]                  o_ram_wdata,
    output logic [AW-1:0]                  o_ram_raddr,
    input  logic [KW-1:0]                  i_ram_rdata
);

    import drmt_pkg::*;

    localparam int CW   = $clog2(MAX_DISPLAYED + 1);
    localparam int RW   = $clog2(RECENT_LIMIT + 1);
    localparam int LMAX = (MAX_DISPLAYED > RECENT_LIMIT) ? MAX_DISPLAYED : RECENT_LIMIT;
    localparam int SW   = $clog2(LMAX + 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_NEXT     = 6'b000010,
        ST_FETCH_LD = 6'b000100,
        ST_SCAN_RD  = 6'b001000,
        ST_SCAN_CMP = 6'b010000,
        ST_OUT      = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        PH_STAGE = 5'b00001,
        PH_QCUR  = 5'b00010,
        PH_QREC  = 5'b00100,
        PH_CCUR  = 5'b01000,
        PH_CREC  = 5'b10000
    } t_phase;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic           r_set_bank, n_set_bank;
    logic           r_rec_bank, n_rec_bank;
    logic [CW-1:0]  r_cur_cnt, n_cur_cnt;
    logic [CW-1:0]  r_pend_cnt, n_pend_cnt;
    logic [RW-1:0]  r_rec_cnt, n_rec_cnt;
    logic [RW-1:0]  r_new_cnt, n_new_cnt;
    logic [SW-1:0]  r_outer, n_outer;
    logic [SW-1:0]  r_idx, n_idx;
    logic [KW-1:0]  r_probe, n_probe;
    t_result        r_res, n_res;

    logic [SW-1:0]  scan_cnt;
    logic [AW-1:0]  scan_addr;
    logic           scan_done;
    logic           scan_found;

    function automatic logic [AW-1:0] set_addr(input logic bank, input logic [SW-1:0] idx);
        return (bank ? AW'(MAX_DISPLAYED) : '0) + AW'(idx);
    endfunction

    function automatic logic [AW-1:0] rec_addr(input logic bank, input logic [SW-1:0] idx);
        return AW'(2 * MAX_DISPLAYED) + (bank ? AW'(RECENT_LIMIT) : '0) + AW'(idx);
    endfunction

    // list under scan for the active phase
    always_comb begin
        unique case (r_phase)
            PH_QCUR: begin
                scan_cnt  = SW'(r_cur_cnt);
                scan_addr = set_addr(r_set_bank, r_idx);
            end
            PH_QREC: begin
                scan_cnt  = SW'(r_rec_cnt);
                scan_addr = rec_addr(r_rec_bank, r_idx);
            end
            default: begin
                scan_cnt  = SW'(r_pend_cnt);
                scan_addr = set_addr(~r_set_bank, r_idx);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_set_bank = r_set_bank;
        n_rec_bank = r_rec_bank;
        n_cur_cnt  = r_cur_cnt;
        n_pend_cnt = r_pend_cnt;
        n_rec_cnt  = r_rec_cnt;
        n_new_cnt  = r_new_cnt;
        n_outer    = r_outer;
        n_idx      = r_idx;
        n_probe    = r_probe;
        n_res      = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = r_probe;
        o_ram_raddr = scan_addr;
        o_res_load  = 1'b0;
        scan_done   = 1'b0;
        scan_found  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_cur_cnt  = '0;
                            n_pend_cnt = '0;
                            n_rec_cnt  = '0;
                        end
                        OP_STAGE: begin
                            if (i_key_valid && (r_pend_cnt < CW'(MAX_DISPLAYED))) begin
                                n_probe = i_key[KW-1:0];
                                n_idx   = '0;
                                n_phase = PH_STAGE;
                                n_state = ST_SCAN_RD;
                            end
                        end
                        OP_COMMIT: begin
                            n_new_cnt = '0;
                            n_outer   = SW'(r_cur_cnt);
                            n_phase   = PH_CCUR;
                            n_state   = ST_NEXT;
                        end
                        OP_QUERY: begin
                            if (i_key_valid) begin
                                n_probe = i_key[KW-1:0];
                                n_idx   = '0;
                                n_phase = PH_QCUR;
                                n_state = ST_SCAN_RD;
                            end else begin
                                n_res.in_current   = 1'b0;
                                n_res.in_recent    = 1'b0;
                                n_res.current_rank = CUR_RANK_W'(r_cur_cnt);
                                n_res.recent_rank  = REC_RANK_W'(r_rec_cnt);
                                n_state            = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_NEXT: begin
                priority if (r_new_cnt == RW'(RECENT_LIMIT) ||
                             (r_phase == PH_CREC && r_outer == SW'(r_rec_cnt))) begin
                    // swap banks: pending becomes current, new list becomes recent
                    n_set_bank = ~r_set_bank;
                    n_cur_cnt  = r_pend_cnt;
                    n_pend_cnt = '0;
                    n_rec_bank = ~r_rec_bank;
                    n_rec_cnt  = r_new_cnt;
                    n_state    = ST_IDLE;
                end else if (r_phase == PH_CCUR) begin
                    if (r_outer == '0) begin
                        n_phase = PH_CREC;
                    end else begin
                        o_ram_raddr = set_addr(r_set_bank, r_outer - SW'(1));
                        n_outer     = r_outer - SW'(1);
                        n_state     = ST_FETCH_LD;
                    end
                end else begin
                    o_ram_raddr = rec_addr(r_rec_bank, r_outer);
                    n_outer     = r_outer + SW'(1);
                    n_state     = ST_FETCH_LD;
                end
            end
            ST_FETCH_LD: begin
                n_probe = i_ram_rdata;
                n_idx   = '0;
                n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (r_idx == scan_cnt) begin
                    scan_done = 1'b1;
                end else begin
                    n_state = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_ram_rdata == r_probe) begin
                    scan_done  = 1'b1;
                    scan_found = 1'b1;
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // scan finished: the index holds the rank, or the count when absent
        if (scan_done) begin
            unique case (r_phase)
                PH_STAGE: begin
                    if (!scan_found) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = set_addr(~r_set_bank, SW'(r_pend_cnt));
                        n_pend_cnt  = r_pend_cnt + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
                PH_QCUR: begin
                    n_res.in_current   = scan_found;
                    n_res.current_rank = CUR_RANK_W'(r_idx);
                    n_idx              = '0;
                    n_phase            = PH_QREC;
                    n_state            = ST_SCAN_RD;
                end
                PH_QREC: begin
                    n_res.in_recent   = scan_found;
                    n_res.recent_rank = REC_RANK_W'(r_idx);
                    n_state           = ST_OUT;
                end
                default: begin
                    if (!scan_found) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = rec_addr(~r_rec_bank, SW'(r_new_cnt));
                        n_new_cnt   = r_new_cnt + RW'(1);
                    end
                    n_state = ST_NEXT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_STAGE;
            r_set_bank <= 1'b0;
            r_rec_bank <= 1'b0;
            r_cur_cnt  <= '0;
            r_pend_cnt <= '0;
            r_rec_cnt  <= '0;
            r_new_cnt  <= '0;
            r_outer    <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_set_bank <= n_set_bank;
            r_rec_bank <= n_rec_bank;
            r_cur_cnt  <= n_cur_cnt;
            r_pend_cnt <= n_pend_cnt;
            r_rec_cnt  <= n_rec_cnt;
            r_new_cnt  <= n_new_cnt;
            r_outer    <= n_outer;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_res   <= n_res;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_res   = r_res;

endmodule

>>> rtl/displayed_recent_mru_tracker.sv
// Tracker of displayed and recently displayed keys. Stage beats (op 1) add a
// valid key to a pending set of up to MAX_DISPLAYED distinct keys; commit
// (op 2) evicts every current key not staged again to the front of a recent
// list (last current entry frontmost), drops staged keys from that list,
// trims it to RECENT_LIMIT and makes the pending set current; query (op 3)
// returns one result beat with membership and rank in both lists, the rank
// being the list length when the key is absent or invalid; clear (op 0)
// empties everything. Only the low KEY_BITS bits of a key are compared.
// All keys live in one single-port-read key RAM and are checked by a single
// comparator, so the cost of a beat is set by that read port: stage and
// query compare the key with the stored entries one at a time, and commit
// checks each current and recent entry against the pending set, ending
// early once the recent list is full. Input stall is high while a beat is
// in progress; a query result waits in an output register and the next
// beat is taken meanwhile. No clearing pass is needed after reset.
module displayed_recent_mru_tracker #(
    parameter int MAX_DISPLAYED = drmt_pkg::MAX_DISPLAYED_DEF,
    parameter int RECENT_LIMIT  = drmt_pkg::RECENT_LIMIT_DEF,
    parameter int KEY_BITS      = drmt_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [drmt_pkg::OP_W-1:0]       i_op,
    input  logic [drmt_pkg::KEY_PORT_W-1:0] i_key,
    input  logic                            i_key_valid,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_in_current,
    output logic                            o_in_recent,
    output logic [drmt_pkg::CUR_RANK_W-1:0] o_current_rank,
    output logic [drmt_pkg::REC_RANK_W-1:0] o_recent_rank
);

    import drmt_pkg::*;

    // compared key width: the port carries 32 bits at most
    localparam int KW    = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    // two set banks (current / pending) and two recent banks (old / new)
    localparam int DEPTH = 2 * MAX_DISPLAYED + 2 * RECENT_LIMIT;
    localparam int AW    = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [KW-1:0] ram_rdata;

    logic          res_load;
    t_result       res;
    logic          out_busy;

    logic          r_o_valid;
    t_result       r_out;

    drmt_key_ram #(
        .DEPTH (DEPTH),
        .W     (KW),
        .AW    (AW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    drmt_ctrl #(
        .MAX_DISPLAYED (MAX_DISPLAYED),
        .RECENT_LIMIT  (RECENT_LIMIT),
        .KW            (KW),
        .AW            (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_key_valid (i_key_valid),
        .i_out_busy  (out_busy),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // the output register is busy only if its beat is held this cycle
    assign out_busy = r_o_valid && i_stall;

    // hold the result beat until taken; load a new one when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_load) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_in_current   = r_out.in_current;
    assign o_in_recent    = r_out.in_recent;
    assign o_current_rank = r_out.current_rank;
    assign o_recent_rank  = r_out.recent_rank;

endmodule
